// ----- rtl/rvaa_pkg.sv -----
// Shared types, constants and the arctangent table for the axis-angle rotator.
package rvaa_pkg;

    localparam int IQ = 28;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [17:0] FULL_TURN    = 18'sd46080;
    localparam logic signed [17:0] HALF_TURN    = 18'sd23040;
    localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;

    // reciprocal of the CORDIC gain, Q.28
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;
    localparam logic signed [32:0] ONE_Q28     = 33'sd268435456;
    localparam logic signed [63:0] HALF_LSB_Q28 = 64'sd134217728;

    localparam logic signed [23:0] OUT_MAX = 24'sd8388607;
    localparam logic signed [23:0] OUT_MIN = -24'sd8388608;

    typedef struct packed {
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] vz;
        logic signed [17:0] ax;
        logic signed [17:0] ay;
        logic signed [17:0] az;
    } item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [33:0] z;
        logic               flip;
    } cordic_t;

    // atan(2^-i) in units of 2^-24 degree
    function automatic logic signed [33:0] atan_deg24(input int idx);
        logic signed [33:0] r;
        case (idx)
            0:  r = 34'sd754974720;
            1:  r = 34'sd445687602;
            2:  r = 34'sd235489088;
            3:  r = 34'sd119537938;
            4:  r = 34'sd60000934;
            5:  r = 34'sd30029717;
            6:  r = 34'sd15018523;
            7:  r = 34'sd7509720;
            8:  r = 34'sd3754917;
            9:  r = 34'sd1877466;
            10: r = 34'sd938734;
            11: r = 34'sd469367;
            12: r = 34'sd234684;
            13: r = 34'sd117342;
            14: r = 34'sd58671;
            15: r = 34'sd29335;
            16: r = 34'sd14668;
            17: r = 34'sd7334;
            18: r = 34'sd3667;
            19: r = 34'sd1833;
            20: r = 34'sd917;
            21: r = 34'sd458;
            22: r = 34'sd229;
            23: r = 34'sd115;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/rvaa_cordic_cell.sv -----
// One CORDIC rotation cell: a micro-rotation plus the word riding alongside it.
module rvaa_cordic_cell #(
    parameter int STAGE_IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  rvaa_pkg::cordic_t in_st,
    input  rvaa_pkg::item_t   in_item,
    output logic              out_valid,
    output rvaa_pkg::cordic_t out_st,
    output rvaa_pkg::item_t   out_item
);

    localparam logic signed [33:0] ATAN = rvaa_pkg::atan_deg24(STAGE_IDX);

    logic              valid_reg;
    rvaa_pkg::cordic_t st_reg, st_next;
    rvaa_pkg::item_t   item_reg;
    logic signed [31:0] dx, dy;

    assign dx = in_st.y >>> STAGE_IDX;
    assign dy = in_st.x >>> STAGE_IDX;

    always_comb begin
        st_next = in_st;
        if (!in_st.z[33]) begin
            st_next.x = in_st.x - dx;
            st_next.y = in_st.y + dy;
            st_next.z = in_st.z - ATAN;
        end else begin
            st_next.x = in_st.x + dx;
            st_next.y = in_st.y - dy;
            st_next.z = in_st.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg   <= st_next;
            item_reg <= in_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;
    assign out_item  = item_reg;

endmodule

// ----- rtl/rvaa_matrix.sv -----
// Builds the Rodrigues matrix from cosine, sine and axis, then applies it to the vector.
module rvaa_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  rvaa_pkg::cordic_t in_st,
    input  rvaa_pkg::item_t   in_item,
    output logic              out_valid,
    output logic [23:0]       out_rot_x,
    output logic [23:0]       out_rot_y,
    output logic [23:0]       out_rot_z
);

    localparam int UP   = (2 * FRAC_BITS < rvaa_pkg::IQ) ? rvaa_pkg::IQ - 2 * FRAC_BITS : 0;
    localparam int DN   = (2 * FRAC_BITS > rvaa_pkg::IQ) ? 2 * FRAC_BITS - rvaa_pkg::IQ : 0;
    localparam logic signed [63:0] RND = (DN > 0) ? (64'sd1 <<< (DN - 1)) : 64'sd0;
    localparam int PW   = 37 + UP;
    localparam int AAW  = 37 + UP - DN;
    localparam int A28W = 18 + rvaa_pkg::IQ - FRAC_BITS;
    localparam int APW  = AAW + 6;
    localparam int ASW  = A28W + 5;
    localparam int MX   = (APW > ASW) ? APW : ASW;
    localparam int MW   = ((MX > 33) ? MX : 33) + 1;
    localparam int PMW  = MW + 24;
    localparam int ACCW = PMW + 3;

    // stage 1
    logic               v1_reg;
    logic signed [32:0] c1_reg, t1_reg;
    logic signed [31:0] s1_reg;
    logic signed [35:0] p1_reg [6];
    rvaa_pkg::item_t    it1_reg;
    logic signed [32:0] c1_next;
    logic signed [17:0] ax [3];

    // stage 2
    logic                   v2_reg;
    logic signed [32:0]     c2_reg;
    logic signed [AAW+32:0] apr2_reg [6];
    logic signed [A28W+31:0] asr2_reg [3];
    rvaa_pkg::item_t        it2_reg;
    logic signed [AAW-1:0]  aq [6];
    logic signed [A28W-1:0] a28 [3];

    // stage 3
    logic                 v3_reg;
    logic signed [MW-1:0] m3_reg [9];
    rvaa_pkg::item_t      it3_reg;
    logic signed [APW-1:0] ap [6];
    logic signed [ASW-1:0] as_ [3];

    // stage 4
    logic                  v4_reg;
    logic signed [PMW-1:0] pm4_reg [9];

    // stage 5
    logic                   v5_reg;
    logic signed [23:0]     rot5_reg [3];
    logic signed [ACCW-1:0] acc [3];
    logic signed [ACCW-1:0] rr [3];
    logic signed [23:0]     sat [3];

    assign ax[0] = in_item.ax;
    assign ax[1] = in_item.ay;
    assign ax[2] = in_item.az;
    assign c1_next = in_st.flip ? -33'(in_st.x) : 33'(in_st.x);

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg    <= c1_next;
            t1_reg    <= rvaa_pkg::ONE_Q28 - c1_next;
            s1_reg    <= in_st.flip ? -in_st.y : in_st.y;
            p1_reg[0] <= ax[0] * ax[0];
            p1_reg[1] <= ax[0] * ax[1];
            p1_reg[2] <= ax[0] * ax[2];
            p1_reg[3] <= ax[1] * ax[1];
            p1_reg[4] <= ax[1] * ax[2];
            p1_reg[5] <= ax[2] * ax[2];
            it1_reg   <= in_item;
        end
    end

    // bring axis products and axis components to Q.28
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            aq[k] = AAW'(((PW'(p1_reg[k]) <<< UP) + RND) >>> DN);
        end
        a28[0] = A28W'(it1_reg.ax) <<< (rvaa_pkg::IQ - FRAC_BITS);
        a28[1] = A28W'(it1_reg.ay) <<< (rvaa_pkg::IQ - FRAC_BITS);
        a28[2] = A28W'(it1_reg.az) <<< (rvaa_pkg::IQ - FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c2_reg <= c1_reg;
            for (int k = 0; k < 6; k++) begin
                apr2_reg[k] <= (AAW+33)'(aq[k]) * (AAW+33)'(t1_reg);
            end
            for (int k = 0; k < 3; k++) begin
                asr2_reg[k] <= (A28W+32)'(a28[k]) * (A28W+32)'(s1_reg);
            end
            it2_reg <= it1_reg;
        end
    end

    // round products back to Q.28, ties up
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            ap[k] = APW'(((AAW+34)'(apr2_reg[k]) + rvaa_pkg::HALF_LSB_Q28) >>> rvaa_pkg::IQ);
        end
        for (int k = 0; k < 3; k++) begin
            as_[k] = ASW'(((A28W+33)'(asr2_reg[k]) + rvaa_pkg::HALF_LSB_Q28)
                          >>> rvaa_pkg::IQ);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m3_reg[0] <= MW'(c2_reg) + MW'(ap[0]);
            m3_reg[1] <= MW'(ap[1]) - MW'(as_[2]);
            m3_reg[2] <= MW'(ap[2]) + MW'(as_[1]);
            m3_reg[3] <= MW'(ap[1]) + MW'(as_[2]);
            m3_reg[4] <= MW'(c2_reg) + MW'(ap[3]);
            m3_reg[5] <= MW'(ap[4]) - MW'(as_[0]);
            m3_reg[6] <= MW'(ap[2]) - MW'(as_[1]);
            m3_reg[7] <= MW'(ap[4]) + MW'(as_[0]);
            m3_reg[8] <= MW'(c2_reg) + MW'(ap[5]);
            it3_reg   <= it2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                pm4_reg[3*r]   <= PMW'(m3_reg[3*r])   * PMW'(it3_reg.vx);
                pm4_reg[3*r+1] <= PMW'(m3_reg[3*r+1]) * PMW'(it3_reg.vy);
                pm4_reg[3*r+2] <= PMW'(m3_reg[3*r+2]) * PMW'(it3_reg.vz);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc[r] = ACCW'(pm4_reg[3*r]) + ACCW'(pm4_reg[3*r+1]) + ACCW'(pm4_reg[3*r+2]);
            rr[r]  = (acc[r] + rvaa_pkg::HALF_LSB_Q28) >>> rvaa_pkg::IQ;
            if (rr[r] > rvaa_pkg::OUT_MAX) begin
                sat[r] = rvaa_pkg::OUT_MAX;
            end else if (rr[r] < rvaa_pkg::OUT_MIN) begin
                sat[r] = rvaa_pkg::OUT_MIN;
            end else begin
                sat[r] = rr[r][23:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                rot5_reg[r] <= sat[r];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_rot_x = rot5_reg[0];
    assign out_rot_y = rot5_reg[1];
    assign out_rot_z = rot5_reg[2];

endmodule

// ----- rtl/rotate_vector_about_axis_3d.sv -----
// Top level: rotates a 3D vector about a unit axis by an angle (axis-angle form).
//
// Input channel s_*: one word carries the vector (Q8.16), the axis (Q1.16,
// taken as unit length) and the angle in 1/128 degree. Output channel m_*:
// one word per input word, the rotated vector, rounded and saturated.
// From acceptance to m_tvalid a word passes one register per CORDIC
// cell in the chain (the angle is reduced in front of the first cell),
// then five matrix and multiply stages, the last of which is the output
// register. Throughput is one word per clock while the output is not
// stalled; every cell and stage moves forward in the same cycle, so a
// new word enters while earlier ones are in flight.
// When the receiver holds m_tready low with m_tvalid high, the whole chain
// holds and s_tready drops in the same cycle; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid flags; the block then
// accepts a word on the next cycle.
module rotate_vector_about_axis_3d #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rot_x, rot_y, rot_z
    output logic [71:0]  m_tdata
);

    logic              en;
    logic              cv    [CORDIC_STAGES+1];
    rvaa_pkg::cordic_t cst   [CORDIC_STAGES+1];
    rvaa_pkg::item_t   citem [CORDIC_STAGES+1];
    logic signed [17:0] ang, red, wrap;
    logic [23:0]        rot_x, rot_y, rot_z;

    // advance the whole chain unless the output word is stuck
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign citem[0].vx = s_tdata[23:0];
    assign citem[0].vy = s_tdata[47:24];
    assign citem[0].vz = s_tdata[71:48];
    assign citem[0].ax = s_tdata[89:72];
    assign citem[0].ay = s_tdata[107:90];
    assign citem[0].az = s_tdata[125:108];
    assign ang         = 18'(signed'(s_tdata[142:126]));
    assign cv[0]       = s_tvalid;

    // reduce to one turn, then fold into the right half plane
    always_comb begin
        if (ang >= rvaa_pkg::FULL_TURN) begin
            red = ang - rvaa_pkg::FULL_TURN;
        end else if (ang >= 18'sd0) begin
            red = ang;
        end else if (ang >= -rvaa_pkg::FULL_TURN) begin
            red = ang + rvaa_pkg::FULL_TURN;
        end else begin
            red = ang + rvaa_pkg::FULL_TURN + rvaa_pkg::FULL_TURN;
        end
        wrap = (red > rvaa_pkg::HALF_TURN) ? red - rvaa_pkg::FULL_TURN : red;
        cst[0].x    = rvaa_pkg::CORDIC_GAIN;
        cst[0].y    = 32'sd0;
        cst[0].flip = 1'b0;
        if (wrap > rvaa_pkg::QUARTER_TURN) begin
            wrap        = wrap - rvaa_pkg::HALF_TURN;
            cst[0].flip = 1'b1;
        end else if (wrap < -rvaa_pkg::QUARTER_TURN) begin
            wrap        = wrap + rvaa_pkg::HALF_TURN;
            cst[0].flip = 1'b1;
        end
        cst[0].z = 34'(wrap) <<< 17;
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        rvaa_cordic_cell #(
            .STAGE_IDX(g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (cv[g]),
            .in_st    (cst[g]),
            .in_item  (citem[g]),
            .out_valid(cv[g+1]),
            .out_st   (cst[g+1]),
            .out_item (citem[g+1])
        );
    end

    rvaa_matrix #(
        .FRAC_BITS(FRAC_BITS)
    ) u_matrix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (cv[CORDIC_STAGES]),
        .in_st    (cst[CORDIC_STAGES]),
        .in_item  (citem[CORDIC_STAGES]),
        .out_valid(m_tvalid),
        .out_rot_x(rot_x),
        .out_rot_y(rot_y),
        .out_rot_z(rot_z)
    );

    assign m_tdata = {rot_z, rot_y, rot_x};

    a_reset_empty: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_tvalid)
        else $error("output word valid right after reset");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output word is stalled");

    a_chain_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(cv[CORDIC_STAGES]) && $stable(cst[CORDIC_STAGES]))
        else $error("cell chain moved during a stall");

endmodule

// ----- tb/sv/rotate_vector_about_axis_3d_tb.sv -----
// Self-checking testbench for the axis-angle 3D vector rotator.
module rotate_vector_about_axis_3d_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES     = 16;
    localparam int FB         = 16;
    localparam int LATENCY    = STAGES + 5;
    localparam int WDOG_LIMIT = 2000;
    localparam int N_RANDOM   = 1930;
    localparam longint TURN      = 46080;
    localparam longint HALF      = 23040;
    localparam longint QUARTER   = 11520;
    localparam longint AXIS_ONE  = 65536;
    localparam longint GAIN_Q28  = 163008219;

    typedef struct packed {
        logic signed [23:0] vx, vy, vz;
        logic signed [17:0] ax, ay, az;
        logic signed [16:0] ang;
    } rot_req_t;

    // rx sits in the lowest bits of the result word
    typedef struct packed {
        logic signed [23:0] rz, ry, rx;
    } rot_vec_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;

    rot_req_t pending_reqs[$];
    rot_vec_t expected_vecs[$];
    int  mismatches = 0;
    int  accepted = 0;
    int  idle_cycles = 0;
    bit  quiet_tail = 0;
    int  src_gap = 0;
    int  sink_gap = 0;

    always #1 aclk = ~aclk;

    rotate_vector_about_axis_3d #(.CORDIC_STAGES(STAGES), .FRAC_BITS(FB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shr(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint q28_mul(longint a, longint b);
        return round_shr(a * b, 28);
    endfunction

    function automatic logic signed [23:0] clamp24(longint v);
        if (v > 8388607) return 24'sh7fffff;
        if (v < -8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic longint atan_step(int i);
        longint tbl[24] = '{754974720, 445687602, 235489088, 119537938, 60000934,
            30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
            234684, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return tbl[i];
    endfunction

    function automatic rot_vec_t rotate_vec(rot_req_t r);
        longint v[3], a[3], a28[3], ap[3][3], m[3][3];
        longint ang, x, y, z, c, s, t, dx, dy, acc;
        bit flip;
        rot_vec_t res;
        v[0] = longint'(r.vx); v[1] = longint'(r.vy); v[2] = longint'(r.vz);
        a[0] = longint'(r.ax); a[1] = longint'(r.ay); a[2] = longint'(r.az);
        for (int i = 0; i < 3; i++) a28[i] = a[i] * (longint'(1) << (28 - FB));
        // fold into one turn, then into +-90 degrees with a sign flip
        ang = longint'(r.ang) % TURN;
        if (ang < 0) ang += TURN;
        if (ang > HALF) ang -= TURN;
        flip = 0;
        if (ang > QUARTER) begin
            ang -= HALF;
            flip = 1;
        end else if (ang < -QUARTER) begin
            ang += HALF;
            flip = 1;
        end
        x = GAIN_Q28;
        y = 0;
        z = ang * 131072;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        t = (longint'(1) << 28) - c;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                ap[i][j] = q28_mul(round_shr(a[i] * a[j], 2 * FB - 28), t);
        m[0][0] = c + ap[0][0];
        m[0][1] = ap[0][1] - q28_mul(a28[2], s);
        m[0][2] = ap[0][2] + q28_mul(a28[1], s);
        m[1][0] = ap[1][0] + q28_mul(a28[2], s);
        m[1][1] = c + ap[1][1];
        m[1][2] = ap[1][2] - q28_mul(a28[0], s);
        m[2][0] = ap[2][0] - q28_mul(a28[1], s);
        m[2][1] = ap[2][1] + q28_mul(a28[0], s);
        m[2][2] = c + ap[2][2];
        acc = m[0][0] * v[0] + m[0][1] * v[1] + m[0][2] * v[2];
        res.rx = clamp24(round_shr(acc, 28));
        acc = m[1][0] * v[0] + m[1][1] * v[1] + m[1][2] * v[2];
        res.ry = clamp24(round_shr(acc, 28));
        acc = m[2][0] * v[0] + m[2][1] * v[1] + m[2][2] * v[2];
        res.rz = clamp24(round_shr(acc, 28));
        return res;
    endfunction

    function automatic logic [143:0] pack_req(rot_req_t r);
        return {1'b0, r.ang, r.az, r.ay, r.ax, r.vz, r.vy, r.vx};
    endfunction

    function automatic rot_req_t mk_req(longint vx, longint vy, longint vz,
                                        longint ax, longint ay, longint az, longint ang);
        rot_req_t r;
        r.vx = 24'(vx); r.vy = 24'(vy); r.vz = 24'(vz);
        r.ax = 18'(ax); r.ay = 18'(ay); r.az = 18'(az);
        r.ang = 17'(ang);
        return r;
    endfunction

    function automatic longint rand_span(longint lo, longint hi);
        return lo + longint'($urandom_range(32'(hi - lo), 0));
    endfunction

    function automatic longint rand_sign_one();
        return $urandom_range(1, 0) ? AXIS_ONE : -AXIS_ONE;
    endfunction

    // axis set to an exact or near-unit direction, or to a random one
    function automatic void rand_unit_axis(ref rot_req_t r);
        int pick;
        longint p, q;
        pick = $urandom_range(5, 0);
        p = rand_span(-AXIS_ONE, AXIS_ONE);
        q = $urandom_range(1, 0) ? longint'(46341) : longint'(-46341);
        case (pick)
            0: begin r.ax = 18'(rand_sign_one()); r.ay = '0; r.az = '0; end
            1: begin r.ax = '0; r.ay = 18'(rand_sign_one()); r.az = '0; end
            2: begin r.ax = '0; r.ay = '0; r.az = 18'(rand_sign_one()); end
            3: begin r.ax = 18'(q); r.ay = 18'(-q); r.az = '0; end
            4: begin
                r.ax = 18'sd37837;
                r.ay = -18'sd37837;
                r.az = q > 0 ? 18'sd37837 : -18'sd37837;
            end
            default: begin
                r.ax = 18'(p);
                r.ay = 18'(rand_span(-AXIS_ONE, AXIS_ONE));
                r.az = 18'(q);
            end
        endcase
    endfunction

    function automatic rot_req_t rand_req(bit wide);
        rot_req_t r;
        int mode;
        mode = $urandom_range(9, 0);
        if (wide || mode == 0) begin
            r.vx = 24'($urandom); r.vy = 24'($urandom); r.vz = 24'($urandom);
        end else begin
            r.vx = 24'(rand_span(-65536 * 4, 65536 * 4));
            r.vy = 24'(rand_span(-65536 * 4, 65536 * 4));
            r.vz = 24'(rand_span(-65536 * 4, 65536 * 4));
        end
        if (mode < 8) begin
            rand_unit_axis(r);
        end else begin
            // raw axis words: any 18-bit pattern
            r.ax = 18'($urandom); r.ay = 18'($urandom); r.az = 18'($urandom);
        end
        if (mode == 9)
            r.ang = 17'($urandom);
        else
            r.ang = 17'(rand_span(-TURN, TURN));
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_vecs.push_back(rotate_vec(pending_reqs.pop_front()));
                accepted <= accepted + 1;
            end
            if (src_gap > 0 && !(s_tvalid && !s_tready)) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (s_tvalid && !s_tready) begin
                // hold the word until taken
            end else if (!quiet_tail && $urandom_range(15, 0) == 0) begin
                src_gap <= $urandom_range(19, 1) - 1;
                s_tvalid <= 1'b0;
            end else if ((s_tvalid && s_tready ? pending_reqs.size() : pending_reqs.size()) > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= pack_req(pending_reqs[0]);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and sink stalls
    always @(posedge aclk) begin
        rot_vec_t got, exp_v;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_vecs.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result word %h", m_tdata);
                end else begin
                    exp_v = expected_vecs.pop_front();
                    if (got.rx !== exp_v.rx || got.ry !== exp_v.ry || got.rz !== exp_v.rz) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                     exp_v.rx, exp_v.ry, exp_v.rz, got.rx, got.ry, got.rz);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(15, 0) == 0) begin
                sink_gap <= $urandom_range(19, 1) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        rot_req_t r;
        int total;
        // directed: field extremes, axis edges, angle folding and wrap
        pending_reqs.push_back(mk_req(65536, 0, 0, 0, 0, AXIS_ONE, 0));
        pending_reqs.push_back(mk_req(65536, 0, 0, 0, 0, AXIS_ONE, QUARTER));
        pending_reqs.push_back(mk_req(65536, 131072, 0, 0, 0, AXIS_ONE, QUARTER + 1));
        pending_reqs.push_back(mk_req(65536, 0, 65536, 0, AXIS_ONE, 0, -QUARTER));
        pending_reqs.push_back(mk_req(65536, 0, 65536, 0, AXIS_ONE, 0, -QUARTER - 1));
        pending_reqs.push_back(mk_req(0, 65536, 65536, AXIS_ONE, 0, 0, HALF));
        pending_reqs.push_back(mk_req(0, 65536, 65536, -AXIS_ONE, 0, 0, -HALF));
        pending_reqs.push_back(mk_req(100, 200, 300, 0, 0, -AXIS_ONE, TURN));
        pending_reqs.push_back(mk_req(100, 200, 300, 0, 0, -AXIS_ONE, -TURN));
        pending_reqs.push_back(mk_req(100, 200, 300, 0, AXIS_ONE, 0, 65535));
        pending_reqs.push_back(mk_req(100, 200, 300, 0, AXIS_ONE, 0, -65536));
        pending_reqs.push_back(mk_req(8388607, 8388607, 8388607, 0, 0, AXIS_ONE, 0));
        pending_reqs.push_back(mk_req(-8388608, -8388608, -8388608, 0, 0, AXIS_ONE, 0));
        pending_reqs.push_back(mk_req(8388607, 8388607, 0, 0, 0, AXIS_ONE, 5760));
        pending_reqs.push_back(mk_req(-8388608, 8388607, -8388608, 37837, 37837, 37837, 15360));
        pending_reqs.push_back(mk_req(8388607, -8388608, 8388607, 131071, 131071, 131071, 1000));
        pending_reqs.push_back(mk_req(8388607, -8388608, 8388607, -131072, -131072, -131072, -1000));
        pending_reqs.push_back(mk_req(65536, 65536, 65536, 0, 0, 0, 7000));
        pending_reqs.push_back(mk_req(65536, 65536, 65536, 46341, 46341, 0, 34560));
        pending_reqs.push_back(mk_req(-1, -1, -1, -1, -1, -1, -1));
        pending_reqs.push_back(mk_req(0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(1, 1, 1, 1, 1, 1, 1));
        total = pending_reqs.size() + N_RANDOM;
        for (int i = 0; i < N_RANDOM; i++) begin
            r = rand_req(i % 8 == 0);
            pending_reqs.push_back(r);
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        while (accepted < total - 200) @(posedge aclk);
        quiet_tail = 1;
        while (accepted < total || expected_vecs.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatches == 0 && expected_vecs.size() == 0 && !m_tvalid) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/rvaa_pkg.sv
rtl/rvaa_cordic_cell.sv
rtl/rvaa_matrix.sv
rtl/rotate_vector_about_axis_3d.sv
tb/sv/rotate_vector_about_axis_3d_tb.sv
